FILE: src/arpre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package arpre_pkg;

  // Default sizing
  localparam int unsigned CACHE_ENTRIES_DEF   = 16;
  localparam int unsigned PENDING_ENTRIES_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF     = 16;

  localparam int unsigned AGE_W   = 20;
  localparam int unsigned DELTA_W = 16;

  localparam logic [AGE_W-1:0] CACHE_LIFE_RST = 20'd30000;
  localparam logic [AGE_W-1:0] PEND_LIFE_RST  = 20'd5000;

  localparam logic [47:0] BCAST_MAC     = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;

  // Request types
  localparam logic [1:0] REQ_SEND  = 2'd0;
  localparam logic [1:0] REQ_FRAME = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_IPV4      = 2'd0;
  localparam logic [1:0] KIND_ARP_REQ   = 2'd1;
  localparam logic [1:0] KIND_ARP_REPLY = 2'd2;
  localparam logic [1:0] KIND_DELIVER   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_OWN_MAC   = 2'd0;
  localparam logic [1:0] CFG_OWN_IP    = 2'd1;
  localparam logic [1:0] CFG_CACHE_LIFE = 2'd2;
  localparam logic [1:0] CFG_PEND_LIFE = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] next_hop_ip;
    logic [15:0] dgram_handle;
    logic [47:0] frame_dst_mac;
    logic [15:0] ether_type;
    logic        payload_ok;
    logic [31:0] arp_sender_ip;
    logic [47:0] arp_sender_mac;
    logic [31:0] arp_target_ip_in;
    logic [15:0] elapsed_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [47:0] out_dst_mac;
    logic [31:0] out_target_ip;
    logic [47:0] out_target_mac;
    logic [15:0] out_handle;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0]      ip;
    logic [47:0]      mac;
    logic [AGE_W-1:0] age;
  } cache_ent_t;

  typedef struct packed {
    logic [31:0]      ip;
    logic [AGE_W-1:0] age;
  } pend_ent_t;

endpackage
`default_nettype wire

FILE: src/arpre_age_sat.sv
`timescale 1ns / 1ps
`default_nettype none
module arpre_age_sat (
  input  wire logic [arpre_pkg::AGE_W-1:0]   age_i,
  input  wire logic [arpre_pkg::DELTA_W-1:0] delta_i,
  input  wire logic [arpre_pkg::AGE_W-1:0]   life_i,
  output logic      [arpre_pkg::AGE_W-1:0]   age_o,
  output logic                               expire_o
);
  import arpre_pkg::*;

  logic [AGE_W:0] sum;

  // Add with saturation, then compare against the lifetime
  assign sum      = {1'b0, age_i} + {{(AGE_W + 1 - DELTA_W){1'b0}}, delta_i};
  assign age_o    = sum[AGE_W] ? {AGE_W{1'b1}} : sum[AGE_W-1:0];
  assign expire_o = (age_o >= life_i);

endmodule
`default_nettype wire

FILE: src/arp_resolution_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                                  Transfer
// request   start, busy, req_i                     start high and busy low
// result    res_valid_o, res_o                     one-cycle strobe, no stall
// config    cfg_we_i, cfg_addr_i, cfg_wdata_i      write when cfg_we_i high
//
// Send: the cache is swept, and on a miss the pending table too; each table
// is swept one entry a cycle through its registered-read memory. Frame with
// learning: both tables are swept and the sender mapping is learned; waiting
// handles are released in queue order, then a reply follows if due. Tick:
// both tables are aged. Delivered datagrams and ignored items need no sweep.
// Reset clears valid bits and queue counts at once; no clearing pass.
// Results leave on a strobe and cannot be held off by the receiver.
module arp_resolution_engine #(
  parameter int unsigned CACHE_ENTRIES   = arpre_pkg::CACHE_ENTRIES_DEF,
  parameter int unsigned PENDING_ENTRIES = arpre_pkg::PENDING_ENTRIES_DEF,
  parameter int unsigned QUEUE_DEPTH     = arpre_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire arpre_pkg::req_t   req_i,
  output logic                   res_valid_o,
  output arpre_pkg::res_t        res_o,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_addr_i,
  input  wire logic [47:0]       cfg_wdata_i
);
  import arpre_pkg::*;

  localparam int unsigned CIW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned PIW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int unsigned MAXE = (CACHE_ENTRIES > PENDING_ENTRIES) ?
                                 CACHE_ENTRIES : PENDING_ENTRIES;
  localparam int unsigned SCW = $clog2(MAXE + 1);
  localparam int unsigned HDEPTH = PENDING_ENTRIES * QUEUE_DEPTH;
  localparam int unsigned HAW = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {OP_SEND, OP_FRAME, OP_TICK} op_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CSCAN = 7'b0000010,
    S_CDEC  = 7'b0000100,
    S_PSCAN = 7'b0001000,
    S_PDEC  = 7'b0010000,
    S_REL   = 7'b0100000,
    S_REPLY = 7'b1000000
  } state_e;

  // Control state
  state_e           state_q, state_d;
  logic [CACHE_ENTRIES-1:0]   cvalid_q, cvalid_d;
  logic [PENDING_ENTRIES-1:0] pvalid_q, pvalid_d;
  logic [QCW-1:0]   pcount_q [PENDING_ENTRIES];
  logic [QCW-1:0]   pcount_d [PENDING_ENTRIES];
  logic [SCW-1:0]   cnt_q, cnt_d;
  logic             pv_q, pv_d;
  logic             hit_q, hit_d;
  logic             maxv_q, maxv_d;
  logic             pfound_q, pfound_d;
  logic             rv_q, rv_d;
  logic [QCW-1:0]   rk_q, rk_d;
  logic             reply_q, reply_d;
  logic             res_valid_q, res_valid_d;
  op_e              op_q, op_d;

  // Configuration
  logic [47:0]      own_mac_q;
  logic [31:0]      own_ip_q;
  logic [AGE_W-1:0] cache_life_q;
  logic [AGE_W-1:0] pend_life_q;

  // Payload registers
  logic [31:0]      ip_q, ip_d;
  logic [15:0]      handle_q, handle_d;
  logic [47:0]      smac_q, smac_d;
  logic [DELTA_W-1:0] elapsed_q, elapsed_d;
  logic [SCW-1:0]   pidx_q, pidx_d;
  logic [CIW-1:0]   hit_idx_q, hit_idx_d;
  logic [47:0]      hit_mac_q, hit_mac_d;
  logic [AGE_W-1:0] max_age_q, max_age_d;
  logic [CIW-1:0]   max_idx_q, max_idx_d;
  logic [PIW-1:0]   pf_idx_q, pf_idx_d;
  logic [QCW-1:0]   rel_cnt_q, rel_cnt_d;
  logic [QCW-1:0]   ridx_q, ridx_d;
  res_t             res_q, res_d;

  // Memories
  cache_ent_t       cache_mem [CACHE_ENTRIES];
  pend_ent_t        pend_mem  [PENDING_ENTRIES];
  logic [15:0]      hnd_mem   [HDEPTH];
  cache_ent_t       cache_rd_q;
  pend_ent_t        pend_rd_q;
  logic [15:0]      hnd_rd_q;

  logic             cache_we;
  logic [CIW-1:0]   cache_waddr;
  cache_ent_t       cache_wdata;
  logic             pend_we;
  logic [PIW-1:0]   pend_waddr;
  pend_ent_t        pend_wdata;
  logic             hnd_we;
  logic [HAW-1:0]   hnd_waddr;
  logic [15:0]      hnd_wdata;
  logic [HAW-1:0]   hnd_raddr;

  logic [AGE_W-1:0] c_age_new, p_age_new;
  logic             c_expire, p_expire;

  logic             cfree_have, pfree_have;
  logic [CIW-1:0]   cfree_idx;
  logic [PIW-1:0]   pfree_idx;

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  arpre_age_sat u_cache_age (
    .age_i    (cache_rd_q.age),
    .delta_i  (elapsed_q),
    .life_i   (cache_life_q),
    .age_o    (c_age_new),
    .expire_o (c_expire)
  );

  arpre_age_sat u_pend_age (
    .age_i    (pend_rd_q.age),
    .delta_i  (elapsed_q),
    .life_i   (pend_life_q),
    .age_o    (p_age_new),
    .expire_o (p_expire)
  );

  // Find the lowest free slot in each table
  always_comb begin
    cfree_have = 1'b0;
    cfree_idx  = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      if (!cvalid_q[i]) begin
        cfree_have = 1'b1;
        cfree_idx  = CIW'(i);
      end
    end
    pfree_have = 1'b0;
    pfree_idx  = '0;
    for (int i = PENDING_ENTRIES - 1; i >= 0; i--) begin
      if (!pvalid_q[i]) begin
        pfree_have = 1'b1;
        pfree_idx  = PIW'(i);
      end
    end
  end

  assign hnd_raddr = HAW'(int'(pf_idx_q) * QUEUE_DEPTH + int'(rk_q));

  // Sequencer
  always_comb begin
    logic [CIW-1:0] cidx;
    logic [PIW-1:0] pidx;
    logic           deliver;
    logic           to_own;
    logic           to_bcast;
    logic [CIW-1:0] slot;
    logic [QCW-1:0] qn;

    state_d     = state_q;
    cvalid_d    = cvalid_q;
    pvalid_d    = pvalid_q;
    pcount_d    = pcount_q;
    cnt_d       = cnt_q;
    pv_d        = 1'b0;
    hit_d       = hit_q;
    maxv_d      = maxv_q;
    pfound_d    = pfound_q;
    rv_d        = 1'b0;
    rk_d        = rk_q;
    reply_d     = reply_q;
    res_valid_d = 1'b0;
    op_d        = op_q;
    ip_d        = ip_q;
    handle_d    = handle_q;
    smac_d      = smac_q;
    elapsed_d   = elapsed_q;
    pidx_d      = pidx_q;
    hit_idx_d   = hit_idx_q;
    hit_mac_d   = hit_mac_q;
    max_age_d   = max_age_q;
    max_idx_d   = max_idx_q;
    pf_idx_d    = pf_idx_q;
    rel_cnt_d   = rel_cnt_q;
    ridx_d      = rk_q;
    res_d       = '0;
    cache_we    = 1'b0;
    cache_waddr = '0;
    cache_wdata = '0;
    pend_we     = 1'b0;
    pend_waddr  = '0;
    pend_wdata  = '0;
    hnd_we      = 1'b0;
    hnd_waddr   = '0;
    hnd_wdata   = '0;
    cidx        = pidx_q[CIW-1:0];
    pidx        = pidx_q[PIW-1:0];
    deliver     = (req_i.frame_dst_mac == own_mac_q) &&
                  (req_i.ether_type == ETH_TYPE_IPV4);
    to_own      = (req_i.frame_dst_mac == own_mac_q);
    to_bcast    = (req_i.frame_dst_mac == BCAST_MAC);
    slot        = hit_q ? hit_idx_q : (cfree_have ? cfree_idx : max_idx_q);
    qn          = pcount_q[pf_idx_q];

    case (state_q)
      S_IDLE: begin
        if (start) begin
          hit_d    = 1'b0;
          maxv_d   = 1'b0;
          pfound_d = 1'b0;
          cnt_d    = '0;
          handle_d = req_i.dgram_handle;
          case (req_i.req_type)
            REQ_SEND: begin
              op_d    = OP_SEND;
              ip_d    = req_i.next_hop_ip;
              state_d = S_CSCAN;
            end
            REQ_FRAME: begin
              if (deliver) begin
                if (req_i.payload_ok) begin
                  res_valid_d      = 1'b1;
                  res_d.out_kind   = KIND_DELIVER;
                  res_d.out_handle = req_i.dgram_handle;
                  res_d.last       = 1'b1;
                end
              end else if (req_i.payload_ok && (to_own || to_bcast)) begin
                op_d    = OP_FRAME;
                ip_d    = req_i.arp_sender_ip;
                smac_d  = req_i.arp_sender_mac;
                reply_d = to_bcast && (req_i.arp_target_ip_in == own_ip_q);
                state_d = S_CSCAN;
              end
            end
            REQ_TICK: begin
              op_d      = OP_TICK;
              elapsed_d = req_i.elapsed_ms;
              state_d   = S_CSCAN;
            end
            default: ;
          endcase
        end
      end

      // Sweep the cache: match, oldest entry, or aging
      S_CSCAN: begin
        if (cnt_q < SCW'(CACHE_ENTRIES)) begin
          cnt_d  = cnt_q + SCW'(1);
          pv_d   = 1'b1;
          pidx_d = cnt_q;
        end
        if (pv_q && cvalid_q[cidx]) begin
          if (op_q == OP_TICK) begin
            cache_we    = 1'b1;
            cache_waddr = cidx;
            cache_wdata = '{ip: cache_rd_q.ip, mac: cache_rd_q.mac, age: c_age_new};
            if (c_expire) cvalid_d[cidx] = 1'b0;
          end else begin
            if (!hit_q && cache_rd_q.ip == ip_q) begin
              hit_d     = 1'b1;
              hit_idx_d = cidx;
              hit_mac_d = cache_rd_q.mac;
            end
            if (!maxv_q || cache_rd_q.age > max_age_q) begin
              maxv_d    = 1'b1;
              max_age_d = cache_rd_q.age;
              max_idx_d = cidx;
            end
          end
        end
        if (pv_q && pidx_q == SCW'(CACHE_ENTRIES - 1)) begin
          cnt_d   = '0;
          pv_d    = 1'b0;
          state_d = (op_q == OP_TICK) ? S_PSCAN : S_CDEC;
        end
      end

      S_CDEC: begin
        if (op_q == OP_SEND) begin
          if (hit_q) begin
            res_valid_d       = 1'b1;
            res_d.out_kind    = KIND_IPV4;
            res_d.out_dst_mac = hit_mac_q;
            res_d.out_handle  = handle_q;
            res_d.last        = 1'b1;
            state_d           = S_IDLE;
          end else begin
            state_d = S_PSCAN;
          end
        end else begin
          // Learn the sender mapping
          cache_we       = 1'b1;
          cache_waddr    = slot;
          cache_wdata    = '{ip: ip_q, mac: smac_q, age: '0};
          cvalid_d[slot] = 1'b1;
          state_d        = S_PSCAN;
        end
      end

      // Sweep the pending table: match or aging
      S_PSCAN: begin
        if (cnt_q < SCW'(PENDING_ENTRIES)) begin
          cnt_d  = cnt_q + SCW'(1);
          pv_d   = 1'b1;
          pidx_d = cnt_q;
        end
        if (pv_q && pvalid_q[pidx]) begin
          if (op_q == OP_TICK) begin
            pend_we    = 1'b1;
            pend_waddr = pidx;
            pend_wdata = '{ip: pend_rd_q.ip, age: p_age_new};
            if (p_expire) begin
              pvalid_d[pidx] = 1'b0;
              pcount_d[pidx] = '0;
            end
          end else if (!pfound_q && pend_rd_q.ip == ip_q) begin
            pfound_d = 1'b1;
            pf_idx_d = pidx;
          end
        end
        if (pv_q && pidx_q == SCW'(PENDING_ENTRIES - 1)) begin
          cnt_d   = '0;
          pv_d    = 1'b0;
          state_d = (op_q == OP_TICK) ? S_IDLE : S_PDEC;
        end
      end

      S_PDEC: begin
        if (op_q == OP_SEND) begin
          state_d = S_IDLE;
          if (pfound_q) begin
            if (qn < QCW'(QUEUE_DEPTH)) begin
              hnd_we             = 1'b1;
              hnd_waddr          = HAW'(int'(pf_idx_q) * QUEUE_DEPTH + int'(qn));
              hnd_wdata          = handle_q;
              pcount_d[pf_idx_q] = qn + QCW'(1);
            end
          end else begin
            res_valid_d          = 1'b1;
            res_d.out_kind       = KIND_ARP_REQ;
            res_d.out_dst_mac    = BCAST_MAC;
            res_d.out_target_ip  = ip_q;
            res_d.last           = 1'b1;
            if (pfree_have) begin
              pvalid_d[pfree_idx] = 1'b1;
              pend_we             = 1'b1;
              pend_waddr          = pfree_idx;
              pend_wdata          = '{ip: ip_q, age: '0};
              hnd_we              = 1'b1;
              hnd_waddr           = HAW'(int'(pfree_idx) * QUEUE_DEPTH);
              hnd_wdata           = handle_q;
              pcount_d[pfree_idx] = QCW'(1);
            end
          end
        end else begin
          if (pfound_q) begin
            // Release the queue and free the entry
            rel_cnt_d          = qn;
            rk_d               = '0;
            pvalid_d[pf_idx_q] = 1'b0;
            pcount_d[pf_idx_q] = '0;
            if (qn != '0) state_d = S_REL;
            else state_d = reply_q ? S_REPLY : S_IDLE;
          end else begin
            state_d = reply_q ? S_REPLY : S_IDLE;
          end
        end
      end

      // Read handles in queue order and emit one per cycle
      S_REL: begin
        if (rk_q < rel_cnt_q) begin
          rk_d = rk_q + QCW'(1);
          rv_d = 1'b1;
        end
        if (rv_q) begin
          res_valid_d       = 1'b1;
          res_d.out_kind    = KIND_IPV4;
          res_d.out_dst_mac = smac_q;
          res_d.out_handle  = hnd_rd_q;
          if (ridx_q == rel_cnt_q - QCW'(1)) begin
            res_d.last = !reply_q;
            rv_d       = 1'b0;
            state_d    = reply_q ? S_REPLY : S_IDLE;
          end
        end
      end

      S_REPLY: begin
        res_valid_d          = 1'b1;
        res_d.out_kind       = KIND_ARP_REPLY;
        res_d.out_dst_mac    = smac_q;
        res_d.out_target_ip  = ip_q;
        res_d.out_target_mac = smac_q;
        res_d.last           = 1'b1;
        state_d              = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cvalid_q    <= '0;
      pvalid_q    <= '0;
      pcount_q    <= '{default: '0};
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      hit_q       <= 1'b0;
      maxv_q      <= 1'b0;
      pfound_q    <= 1'b0;
      rv_q        <= 1'b0;
      rk_q        <= '0;
      reply_q     <= 1'b0;
      res_valid_q <= 1'b0;
      op_q        <= OP_SEND;
    end else begin
      state_q     <= state_d;
      cvalid_q    <= cvalid_d;
      pvalid_q    <= pvalid_d;
      pcount_q    <= pcount_d;
      cnt_q       <= cnt_d;
      pv_q        <= pv_d;
      hit_q       <= hit_d;
      maxv_q      <= maxv_d;
      pfound_q    <= pfound_d;
      rv_q        <= rv_d;
      rk_q        <= rk_d;
      reply_q     <= reply_d;
      res_valid_q <= res_valid_d;
      op_q        <= op_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q    <= '0;
      own_ip_q     <= '0;
      cache_life_q <= CACHE_LIFE_RST;
      pend_life_q  <= PEND_LIFE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_OWN_MAC:    own_mac_q    <= cfg_wdata_i;
        CFG_OWN_IP:     own_ip_q     <= cfg_wdata_i[31:0];
        CFG_CACHE_LIFE: cache_life_q <= cfg_wdata_i[AGE_W-1:0];
        CFG_PEND_LIFE:  pend_life_q  <= cfg_wdata_i[AGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ip_q      <= ip_d;
    handle_q  <= handle_d;
    smac_q    <= smac_d;
    elapsed_q <= elapsed_d;
    pidx_q    <= pidx_d;
    hit_idx_q <= hit_idx_d;
    hit_mac_q <= hit_mac_d;
    max_age_q <= max_age_d;
    max_idx_q <= max_idx_d;
    pf_idx_q  <= pf_idx_d;
    rel_cnt_q <= rel_cnt_d;
    ridx_q    <= ridx_d;
    res_q     <= res_d;
  end

  // Cache memory
  always_ff @(posedge clk_i) begin
    if (cache_we) cache_mem[cache_waddr] <= cache_wdata;
    cache_rd_q <= cache_mem[cnt_q[CIW-1:0]];
  end

  // Pending table memory
  always_ff @(posedge clk_i) begin
    if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
    pend_rd_q <= pend_mem[cnt_q[PIW-1:0]];
  end

  // Handle queue memory
  always_ff @(posedge clk_i) begin
    if (hnd_we) hnd_mem[hnd_waddr] <= hnd_wdata;
    hnd_rd_q <= hnd_mem[hnd_raddr];
  end

endmodule
`default_nettype wire

FILE: src/arpre_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module arpre_chk (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            start,
  input wire logic            busy,
  input wire arpre_pkg::req_t req_i,
  input wire logic            res_valid_o,
  input wire arpre_pkg::res_t res_o
);
  import arpre_pkg::*;

  // A request broadcast is a single, final result
  a_arp_req_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.out_kind == KIND_ARP_REQ |->
      res_o.out_dst_mac == BCAST_MAC && res_o.out_handle == '0 && res_o.last)
    else $error("malformed ARP request result");

  // A delivered datagram ends its transaction
  a_deliver_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.out_kind == KIND_DELIVER |->
      res_o.last && res_o.out_dst_mac == '0)
    else $error("delivered datagram not last");

  // A reply targets its own destination and closes the transaction
  a_reply_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.out_kind == KIND_ARP_REPLY |->
      res_o.last && res_o.out_target_mac == res_o.out_dst_mac)
    else $error("malformed ARP reply");

  // A tick always sweeps the tables
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.req_type == REQ_TICK |=> busy)
    else $error("tick did not start a sweep");

  // Unknown request types are dropped at once
  a_unknown_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.req_type == REQ_NONE |=> !busy && !res_valid_o)
    else $error("unknown request type was acted on");

endmodule

bind arp_resolution_engine arpre_chk u_arpre_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .req_i       (req_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
`default_nettype wire
